FILE: hw/rtl/idrm_pkg.sv
// ----------------------------------------------------------------------------
// idrm_pkg
// Shared types and constants of the int8 dot product and requantize block.
// ----------------------------------------------------------------------------
`default_nettype none

package idrm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_INPUT_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_OFFSET = 2'd1;
  localparam logic [1:0] CFG_ACT_MIN       = 2'd2;
  localparam logic [1:0] CFG_ACT_MAX       = 2'd3;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // packed input item: activation, weight, bias, multiplier, shift_amount
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MUL,
    ST_SRDHM,
    ST_RSHIFT,
    ST_OUT
  } idrm_state_t;

  typedef struct packed {
    logic acc_add;     // accumulate the accepted item's product
    logic capture;     // hold the channel parameters of a last item
    logic bias_shift;  // add bias, shift left, clear the accumulator
    logic mul;         // full multiply by the channel multiplier
    logic srdhm;       // rounded high word
    logic rshift;      // rounding right shift
    logic out_load;    // offset, clamp and load the output register
  } idrm_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a new item this cycle
  } idrm_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/idrm_ctrl.sv
// ----------------------------------------------------------------------------
// idrm_ctrl
// Sequencer: accepts items and steps a last item through requantization.
// ----------------------------------------------------------------------------
`default_nettype none

module idrm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  input  wire                 in_tlast,
  output logic                in_tready,
  input  idrm_pkg::idrm_stat_t stat,
  output idrm_pkg::idrm_cmd_t  cmd
);

  idrm_pkg::idrm_state_t state_r;
  idrm_pkg::idrm_state_t state_nxt;
  logic                  accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      idrm_pkg::ST_IDLE: begin
        if (accept && in_tlast) begin
          state_nxt = idrm_pkg::ST_BIAS;
        end
      end
      idrm_pkg::ST_BIAS:   state_nxt = idrm_pkg::ST_MUL;
      idrm_pkg::ST_MUL:    state_nxt = idrm_pkg::ST_SRDHM;
      idrm_pkg::ST_SRDHM:  state_nxt = idrm_pkg::ST_RSHIFT;
      idrm_pkg::ST_RSHIFT: state_nxt = idrm_pkg::ST_OUT;
      idrm_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = idrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = idrm_pkg::ST_IDLE;
    endcase
  end

  // in idle the input is always ready, so a valid item is an accepted one
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      idrm_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.acc_add = in_tvalid;
        cmd.capture = in_tvalid && in_tlast;
      end
      idrm_pkg::ST_BIAS:   cmd.bias_shift = 1'b1;
      idrm_pkg::ST_MUL:    cmd.mul        = 1'b1;
      idrm_pkg::ST_SRDHM:  cmd.srdhm      = 1'b1;
      idrm_pkg::ST_RSHIFT: cmd.rshift     = 1'b1;
      idrm_pkg::ST_OUT:    cmd.out_load   = stat.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/idrm_dpath.sv
// ----------------------------------------------------------------------------
// idrm_dpath
// Accumulator, requantization steps, configuration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idrm_dpath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [idrm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [idrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire  signed [7:0]                   activation,
  input  wire  signed [7:0]                   weight,
  input  wire  signed [31:0]                  bias,
  input  wire  [30:0]                         multiplier,
  input  wire  signed [5:0]                   shift_amount,
  input  idrm_pkg::idrm_cmd_t                 cmd,
  output idrm_pkg::idrm_stat_t                stat,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic signed [7:0]                   out_value
);

  // configuration
  logic signed [8:0]  in_off_r;
  logic signed [7:0]  out_off_r;
  logic signed [7:0]  act_min_r;
  logic signed [7:0]  act_max_r;

  // accumulation and channel parameters
  logic [31:0]        acc_r;
  logic [31:0]        acc_nxt;
  logic [31:0]        bias_r;
  logic [30:0]        mult_r;
  logic [4:0]         lsh_r;
  logic [4:0]         rsh_r;

  // requantization pipeline registers
  logic [31:0]        x_r;
  logic signed [62:0] ab_r;
  logic signed [31:0] hi_r;
  logic signed [31:0] rs_r;
  logic signed [7:0]  out_data_r;
  logic               out_valid_r;

  logic signed [9:0]  act_off;
  logic signed [17:0] prod;
  logic [31:0]        acc_sum;
  logic [4:0]         lsh_nxt;
  logic [4:0]         rsh_nxt;
  logic [5:0]         neg_shift;
  logic signed [63:0] ab_full;
  logic signed [62:0] ab_rnd;
  logic [31:0]        mask;
  logic [31:0]        rem;
  logic [31:0]        thr;
  logic signed [31:0] q;
  logic signed [31:0] rs_nxt;
  logic signed [32:0] v;
  logic signed [32:0] v_lo;
  logic signed [32:0] v_cl;

  // product at full width: offset activation is not truncated
  assign act_off = 10'(activation) + 10'(in_off_r);
  assign prod    = 18'(act_off) * 18'(weight);
  assign acc_sum = acc_r + 32'(prod);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.bias_shift) begin
      acc_nxt = '0;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_sum;
    end
  end

  // positive exponent shifts left, negative rounds right (saturates at 31)
  assign neg_shift = 6'(-shift_amount);
  always_comb begin
    if (shift_amount > 6'sd0) begin
      lsh_nxt = shift_amount[4:0];
      rsh_nxt = 5'd0;
    end else begin
      lsh_nxt = 5'd0;
      rsh_nxt = neg_shift[5] ? 5'd31 : neg_shift[4:0];
    end
  end

  // doubling high multiply: floor((ab + 2^30) / 2^31) equals the
  // truncating divide of the nudged product for both signs
  assign ab_full = $signed(x_r) * $signed({1'b0, mult_r});
  assign ab_rnd  = ab_r + 63'sd1073741824;

  // rounding right shift, ties away from zero
  assign mask   = ~(32'hFFFF_FFFF << rsh_r);
  assign rem    = hi_r & mask;
  assign thr    = (mask >> 1) + {31'd0, hi_r[31]};
  assign q      = hi_r >>> rsh_r;
  assign rs_nxt = q + $signed({31'd0, (rem > thr)});

  // offset at full width, raise to min then lower to max
  assign v    = 33'(rs_r) + 33'(out_off_r);
  assign v_lo = (v < 33'(act_min_r)) ? 33'(act_min_r) : v;
  assign v_cl = (v_lo > 33'(act_max_r)) ? 33'(act_max_r) : v_lo;

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_off_r    <= '0;
      out_off_r   <= '0;
      act_min_r   <= -8'sd128;
      act_max_r   <= 8'sd127;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          idrm_pkg::CFG_INPUT_OFFSET:  in_off_r  <= cfg_wdata;
          idrm_pkg::CFG_OUTPUT_OFFSET: out_off_r <= cfg_wdata[7:0];
          idrm_pkg::CFG_ACT_MIN:       act_min_r <= cfg_wdata[7:0];
          idrm_pkg::CFG_ACT_MAX:       act_max_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      acc_r <= acc_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bias_r <= bias;
      mult_r <= multiplier;
      lsh_r  <= lsh_nxt;
      rsh_r  <= rsh_nxt;
    end
    if (cmd.bias_shift) begin
      x_r <= (acc_r + bias_r) << lsh_r;
    end
    if (cmd.mul) begin
      ab_r <= ab_full[62:0];
    end
    if (cmd.srdhm) begin
      hi_r <= ab_rnd[62:31];
    end
    if (cmd.rshift) begin
      rs_r <= rs_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= v_cl[7:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/int8_dot_requant_mac.sv
// ----------------------------------------------------------------------------
// int8_dot_requant_mac
// Int8 dot product with per-channel requantization to one int8 output.
// ----------------------------------------------------------------------------
// Each input item carries one activation/weight pair and is multiplied and
// accumulated in the cycle it is accepted, so a run of items that are not
// marked last goes in at one item per cycle. The item marked with tlast also
// carries the channel's bias, multiplier and shift; after it the block steps
// through requantization (bias and left shift, the 32x31 multiply, rounded
// high word, rounding right shift, offset and clamp), taking the next item
// once the result is loaded into a free output register. The result waits
// there to be taken while the next run starts. Configuration is to be written
// by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_dot_requant_mac (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [idrm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [idrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // activation[7:0], weight[15:8], bias[47:16], multiplier[78:48],
  // shift_amount[84:79], zero fill[87:85]
  input  wire  [idrm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                                 in_tlast,   // last_element
  // result items
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [idrm_pkg::OUT_DATA_W-1:0]     out_tdata   // out_value[7:0]
);

  idrm_pkg::idrm_cmd_t  cmd;
  idrm_pkg::idrm_stat_t stat;
  logic signed [7:0]    out_value;

  idrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  idrm_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .activation   (in_tdata[7:0]),
    .weight       (in_tdata[15:8]),
    .bias         (in_tdata[47:16]),
    .multiplier   (in_tdata[78:48]),
    .shift_amount (in_tdata[84:79]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_value    (out_value)
  );

  assign out_tdata = out_value;

endmodule

`default_nettype wire

FILE: bench/tb_int8_dot_requant_mac.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int8_dot_requant_mac
// Self-checking bench for the int8 dot product and requantize block.
// ----------------------------------------------------------------------------
// Streams activation/weight items in runs closed by tlast, predicts every
// requantized output with a bit-accurate model of the accumulate, saturating
// rounding doubling high multiply, rounding right shift, offset and clamp,
// and compares each output item in order. Directed runs hit the field and
// register extremes, then random runs go through four idling phases, one of
// them with a long output stall that backs the block up.
// ----------------------------------------------------------------------------

module tb_int8_dot_requant_mac;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          RUN_ITEMS      = 150;
  localparam logic [30:0] MULT_MAX       = 31'h7FFF_FFFF;
  localparam logic [30:0] MULT_HALF      = 31'h4000_0000;

  // expected output values, oldest first, plus the model's own register copy
  class requant_scoreboard;
    logic signed [8:0] in_off;
    logic signed [7:0] out_off;
    logic signed [7:0] lo_clamp;
    logic signed [7:0] hi_clamp;
    logic [31:0]       acc;
    logic [7:0]        expected_q[$];
    int                items_seen;
    int                results_seen;
    int                errors;

    function new();
      in_off   = '0;
      out_off  = '0;
      lo_clamp = -8'sd128;
      hi_clamp = 8'sd127;
      acc      = '0;
    endfunction

    function void set_config(logic [idrm_pkg::CFG_ADDR_W-1:0] idx,
                             logic [idrm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        idrm_pkg::CFG_INPUT_OFFSET:  in_off   = val;
        idrm_pkg::CFG_OUTPUT_OFFSET: out_off  = val[7:0];
        idrm_pkg::CFG_ACT_MIN:       lo_clamp = val[7:0];
        idrm_pkg::CFG_ACT_MAX:       hi_clamp = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [idrm_pkg::IN_DATA_W-1:0] data, logic last);
      logic signed [7:0]  a;
      logic signed [7:0]  w;
      logic signed [31:0] b;
      logic [30:0]        m;
      logic signed [5:0]  sh;
      int                 lsh;
      int                 rsh;
      int                 x;
      longint             ab;
      longint             nudge;
      longint             v;
      logic [31:0]        msk;
      logic [31:0]        rem;
      logic [31:0]        thr;
      a  = data[7:0];
      w  = data[15:8];
      b  = data[47:16];
      m  = data[78:48];
      sh = data[84:79];
      items_seen++;
      // offset activation kept at full width, no wrap to 8 bits
      acc = acc + ((int'(a) + int'(in_off)) * int'(w));
      if (!last) return;
      acc = acc + b;
      lsh = (sh > 0) ? int'(sh) : 0;
      rsh = (sh > 0) ? 0 : -int'(sh);
      if (rsh > 31) rsh = 31;
      x = acc << lsh;
      // multiplier is never negative, so the saturating corner cannot occur
      ab    = longint'(x) * longint'({33'd0, m});
      nudge = (ab >= 0) ? 64'sd1073741824 : -64'sd1073741823;
      x     = int'((ab + nudge) / 64'sd2147483648);
      msk = 32'((64'd1 << rsh) - 64'd1);
      rem = x & msk;
      thr = (msk >> 1) + ((x < 0) ? 32'd1 : 32'd0);
      x   = (x >>> rsh) + ((rem > thr) ? 1 : 0);
      // raise to the floor first, so an inverted window yields the ceiling
      v = longint'(x) + longint'(out_off);
      if (v < longint'(lo_clamp)) v = lo_clamp;
      if (v > longint'(hi_clamp)) v = hi_clamp;
      expected_q.push_back(v[7:0]);
      acc = '0;
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t out_value mismatch: expected none, got %0d", $time, $signed(got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t out_value mismatch: expected %0d, got %0d", $time,
                 $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [idrm_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [idrm_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [idrm_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [idrm_pkg::OUT_DATA_W-1:0] out_tdata;

  requant_scoreboard sb;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_go      = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  int tx_tab[4] = '{0, 53, 0, 17};
  int rx_tab[4] = '{0, 0, 53, 17};

  int8_dot_requant_mac dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic signed [7:0] act, input logic signed [7:0] wgt,
                           input logic signed [31:0] bias, input logic [30:0] mult,
                           input logic signed [5:0] shamt, input logic last);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, shamt, mult, bias, wgt, act};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // lets every expected output drain and the requantizer fall idle
  task automatic settle();
    in_tvalid <= 1'b0;
    // wait on a clock edge first, so the item accepted at the previous edge is noted
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [idrm_pkg::CFG_DATA_W-1:0] ioff,
                           input logic [idrm_pkg::CFG_DATA_W-1:0] ooff,
                           input logic [idrm_pkg::CFG_DATA_W-1:0] lo,
                           input logic [idrm_pkg::CFG_DATA_W-1:0] hi);
    logic [idrm_pkg::CFG_ADDR_W-1:0] regs[4];
    logic [idrm_pkg::CFG_DATA_W-1:0] vals[4];
    regs = '{idrm_pkg::CFG_INPUT_OFFSET, idrm_pkg::CFG_OUTPUT_OFFSET,
             idrm_pkg::CFG_ACT_MIN, idrm_pkg::CFG_ACT_MAX};
    vals = '{ioff, ooff, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      sb.set_config(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(7))
      0:       return 8'h80;
      1:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // channels of random length, mostly short, with random channel parameters
  task automatic run_channels(input int n_items);
    int                 sent;
    int                 len;
    logic signed [31:0] bias;
    logic [30:0]        mult;
    logic signed [5:0]  shamt;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        bias = $urandom_range(1) ? (int'($urandom_range(10000)) - 5000) : $urandom();
        case ($urandom_range(9))
          0:       mult = '0;
          1:       mult = MULT_MAX;
          2, 3, 4, 5, 6: mult = MULT_HALF | 31'($urandom());
          default: mult = 31'($urandom());
        endcase
        shamt = ($urandom_range(2) != 0) ? 6'(-int'($urandom_range(4, 14)))
                                         : 6'($urandom_range(63));
        send_item(rand_operand(), rand_operand(), bias, mult, shamt, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: extremes of the operands and of the shift
    send_item(8'sd127, 8'sd127, 32'sd0, MULT_MAX, 6'sd0, 1'b1);
    send_item(-8'sd128, -8'sd128, 32'sh8000_0000, MULT_HALF, 6'sd31, 1'b1);
    send_item(-8'sd128, 8'sd127, 32'sh7FFF_FFFF, MULT_MAX, -6'sd32, 1'b1);
    send_item(8'sd5, -8'sd7, -32'sd1000, 31'd0, -6'sd31, 1'b1);
    // bias and multiplier on non-last items must be ignored
    send_item(8'sd100, -8'sd100, 32'sd0, 31'd0, 6'sd0, 1'b0);
    send_item(-8'sd1, 8'sd1, 32'sd123456, MULT_HALF, -6'sd1, 1'b0);
    send_item(8'sd3, 8'sd3, -32'sd7, MULT_HALF, -6'sd1, 1'b1);
    send_item(8'sd0, 8'sd0, -32'sd12, MULT_MAX, 6'sd1, 1'b1);
    settle();

    // widest input offset, output offset large enough to pass the clamp
    configure(9'd255, 9'd127, -9'sd128, 9'd127);
    send_item(8'sd127, -8'sd128, 32'sd0, MULT_MAX, -6'sd8, 1'b1);
    send_item(8'sd0, 8'sd0, 32'sd5000, MULT_MAX, 6'sd0, 1'b1);
    send_item(-8'sd128, 8'sd127, -32'sd40, MULT_MAX, 6'sd0, 1'b1);
    settle();

    // most negative offsets and an inverted clamp window
    configure(9'h100, 9'h180, 9'd50, -9'sd50);
    send_item(-8'sd128, 8'sd127, 32'sd0, MULT_MAX, -6'sd4, 1'b1);
    send_item(8'sd127, -8'sd128, 32'sd0, MULT_MAX, -6'sd20, 1'b1);
    settle();

    configure(9'd1, 9'd5, -9'sd10, 9'd10);
    send_item(8'sd20, 8'sd30, 32'sd0, MULT_MAX, -6'sd6, 1'b1);
    send_item(-8'sd20, 8'sd30, 32'sd0, MULT_MAX, -6'sd6, 1'b1);
    settle();

    for (int p = 0; p < 4; p++) begin
      configure(9'($urandom_range(511)),
                {1'($urandom_range(1)), 8'($urandom_range(255))},
                {1'($urandom_range(1)), 8'(-int'($urandom_range(1, 128)))},
                {1'($urandom_range(1)), 8'($urandom_range(127))});
      tx_idle_pct  = tx_tab[p];
      rx_stall_pct = rx_tab[p];
      // long output hold-off while items keep coming, so the input backs up
      if (p == 0) hold_go = 1'b1;
      run_channels(RUN_ITEMS);
      settle();
    end

    $display("covered %0d input items and %0d output items over four idling phases,",
             sb.items_seen, sb.results_seen);
    $display("with register extremes, an inverted clamp and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: int8_dot_requant_mac.f
hw/rtl/idrm_pkg.sv
hw/rtl/idrm_ctrl.sv
hw/rtl/idrm_dpath.sv
hw/rtl/int8_dot_requant_mac.sv
bench/tb_int8_dot_requant_mac.sv
